// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/ntczf_pkg.sv =====
// Types, constants and helpers of the NTC zone and temperature filter.
// No dependencies; used by ntc_zone_and_temperature_filter.
package ntczf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_OPEN_THR    = 3'd0;
    localparam logic [2:0] REG_RECOVER_THR = 3'd1;
    localparam logic [2:0] REG_OVER_THR    = 3'd2;
    localparam logic [2:0] REG_SHORT_THR   = 3'd3;
    localparam logic [2:0] REG_TEMP_LIMIT  = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd5;

    // Request kinds on tuser
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TABLE  = 1'b1;

    // Field widths
    localparam int CFG_W    = 11;
    localparam int ZONE_W   = 3;
    localparam int TEMP_W   = 11;
    localparam int RAW_W    = 12;   // md*10+5 for md up to 255
    localparam int SUM_W    = 14;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 32;

    // Filter weight is a power of two: divide by shifting
    localparam int FILT_SHIFT = 2;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [TEMP_W-1:0] FILT_MAX = {TEMP_W{1'b1}};

    localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = 11'd1500;
    localparam logic [7:0]        DEBOUNCE_RST   = 8'd50;
    localparam logic [7:0]        COUNT_MAX      = 8'd255;

    // Zone codes
    localparam logic [ZONE_W-1:0] ZONE_INIT    = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_OPEN    = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_RECOVER = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_OVER    = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_HIGH    = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_SHORT   = 3'd5;

    // Table index times ten, by shift and add
    function automatic logic [RAW_W-1:0] times10(input logic [7:0] idx);
        logic [RAW_W-1:0] ext;
        ext = RAW_W'(idx);
        return (ext << 3) + (ext << 1);
    endfunction

endpackage

// ===== rtl/ntc_zone_and_temperature_filter.sv =====
// NTC zone detector with debounce and table-based temperature filter.
// Depends on ntczf_pkg.
//
// A sample request (tuser = 0) is taken in its accept cycle: its zone and the debounced held
// zone are settled at once; then a small sequencer binary-searches the lookup table
// stored in a one-write, two-read memory with registered read data, one search step
// per cycle (entries md and md+1 read together). After ENDS checks the table ends, a
// sample passes through STEP once per search step, unless the ends settle it, and then
// FILTER, before its result enters the output register; FILTER waits while the previous
// result still waits there, and s_tready is low over that time. A table request
// (tuser = 1) writes one entry in its accept cycle and returns no result. The table
// has no reset: every entry must be loaded before samples are sent. Results are held
// in an output register, so a new request may be accepted while the last result waits
// to be taken.
module ntc_zone_and_temperature_filter #(
    parameter int TABLE_ENTRIES = 180
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [ntczf_pkg::CFG_W-1:0]    cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ntczf_pkg::IN_W-1:0]     s_tdata,   // sample[7:0], table_index[15:8],
                                                      // table_value[23:16]
    input  logic                           s_tuser,   // mode[0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ntczf_pkg::OUT_W-1:0]    m_tdata    // zone[2:0], raw_temperature[13:3],
                                                      // filtered_temperature[24:14], zero
);

    localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [ntczf_pkg::RAW_W-1:0] LAST_TEMP =
        ntczf_pkg::RAW_W'((TABLE_ENTRIES - 1) * 10);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENDS,
        ST_STEP,
        ST_FILTER
    } state_t;

    // Configuration registers
    logic [7:0]                        open_thr_reg, recover_thr_reg;
    logic [7:0]                        over_thr_reg, short_thr_reg;
    logic [ntczf_pkg::TEMP_W-1:0]      temp_limit_reg;
    logic [7:0]                        debounce_reg;

    // Control and datapath state
    state_t                            state_reg, state_next;
    logic [ntczf_pkg::ZONE_W-1:0]      held_zone_reg, held_zone_next;
    logic [7:0]                        count_reg, count_next;
    logic [ntczf_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [7:0]                        x_reg, x_next;
    logic [IDX_W-1:0]                  st_reg, st_next;
    logic [IDX_W-1:0]                  ed_reg, ed_next;
    logic [IDX_W-1:0]                  md_reg, md_next;
    logic [ntczf_pkg::RAW_W-1:0]       raw_reg, raw_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [ntczf_pkg::OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    // Lookup table memory
    logic [7:0]                        table_mem [TABLE_ENTRIES];
    logic [7:0]                        rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0]                  rd_addr_a, rd_addr_b;
    logic                              tbl_we;

    // Request fields
    logic                              in_req;
    logic [7:0]                        in_sample, in_index, in_value;
    logic [ntczf_pkg::ZONE_W-1:0]      new_zone;

    // Search step helpers
    logic [IDX_W:0]                    mid_sum;
    logic [IDX_W-1:0]                  ns, ne;
    logic [ntczf_pkg::RAW_W-1:0]       md_times10;

    // Filter helpers
    localparam int FILT_SHIFT_W = ntczf_pkg::FILT_SHIFT;
    logic [ntczf_pkg::TEMP_W-1:0]      t_val;
    logic [ntczf_pkg::SUM_W-1:0]       sum_seed;
    logic [ntczf_pkg::SUM_W:0]         sum_upd;
    logic [ntczf_pkg::SUM_W-1:0]       sum_sat;
    logic [ntczf_pkg::SUM_W-FILT_SHIFT_W-1:0] filt_full;
    logic [ntczf_pkg::TEMP_W-1:0]      filt_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_req    = s_tvalid && s_tready;
    assign in_sample = s_tdata[7:0];
    assign in_index  = s_tdata[15:8];
    assign in_value  = s_tdata[23:16];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign tbl_we = in_req && (s_tuser == ntczf_pkg::MODE_TABLE)
                    && ({1'b0, in_index} < 9'(TABLE_ENTRIES));

    // Zone of the incoming reading
    always_comb begin
        if (in_sample < open_thr_reg) begin
            new_zone = ntczf_pkg::ZONE_OPEN;
        end else if (in_sample < recover_thr_reg) begin
            new_zone = ntczf_pkg::ZONE_RECOVER;
        end else if (in_sample < over_thr_reg) begin
            new_zone = ntczf_pkg::ZONE_OVER;
        end else if (in_sample < short_thr_reg) begin
            new_zone = ntczf_pkg::ZONE_HIGH;
        end else begin
            new_zone = ntczf_pkg::ZONE_SHORT;
        end
    end

    // One search step on the interval, entries md and md+1 in rd_a/rd_b
    always_comb begin
        ns = st_reg;
        ne = ed_reg;
        if (x_reg > rd_a_reg) begin
            ne = md_reg;
        end else begin
            ns = md_reg;
        end
        mid_sum    = {1'b0, ns} + {1'b0, ne};
        md_times10 = ntczf_pkg::times10(8'(md_reg));
    end

    // Running average update
    always_comb begin
        if (raw_reg == '0 || raw_reg > ntczf_pkg::RAW_W'(temp_limit_reg)) begin
            t_val = '0;
        end else begin
            t_val = raw_reg[ntczf_pkg::TEMP_W-1:0];
        end
        if (sum_reg == '0) begin
            sum_seed = ntczf_pkg::SUM_W'({t_val, {FILT_SHIFT_W{1'b0}}});
        end else begin
            sum_seed = sum_reg;
        end
        sum_upd = {1'b0, sum_seed - (sum_seed >> FILT_SHIFT_W)}
                  + (ntczf_pkg::SUM_W + 1)'(t_val);
        sum_sat = sum_upd[ntczf_pkg::SUM_W] ? ntczf_pkg::SUM_MAX
                                            : sum_upd[ntczf_pkg::SUM_W-1:0];
        filt_full = sum_sat[ntczf_pkg::SUM_W-1:FILT_SHIFT_W];
        if (filt_full > (ntczf_pkg::SUM_W - FILT_SHIFT_W)'(ntczf_pkg::FILT_MAX)) begin
            filt_val = ntczf_pkg::FILT_MAX;
        end else begin
            filt_val = filt_full[ntczf_pkg::TEMP_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        held_zone_next = held_zone_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        st_next        = st_reg;
        ed_next        = ed_reg;
        md_next        = md_reg;
        raw_next       = raw_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        rd_addr_a      = '0;
        rd_addr_b      = LAST_IDX;

        case (state_reg)
            ST_IDLE: begin
                if (in_req && s_tuser == ntczf_pkg::MODE_SAMPLE) begin
                    // debounce the zone right away
                    if (held_zone_reg == new_zone) begin
                        count_next = '0;
                    end else if (count_reg < ntczf_pkg::COUNT_MAX) begin
                        count_next = count_reg + 8'd1;
                    end
                    if (count_next > debounce_reg) begin
                        held_zone_next = new_zone;
                    end
                    x_next     = ~in_sample;
                    state_next = ST_ENDS;
                end
            end
            ST_ENDS: begin
                // rd_a = first entry, rd_b = last entry
                st_next   = '0;
                ed_next   = LAST_IDX;
                md_next   = IDX_W'({1'b0, LAST_IDX} >> 1);
                rd_addr_a = md_next;
                rd_addr_b = md_next + IDX_W'(1);
                if (x_reg >= rd_a_reg) begin
                    raw_next   = '0;
                    state_next = ST_FILTER;
                end else if (x_reg <= rd_b_reg) begin
                    raw_next   = LAST_TEMP;
                    state_next = ST_FILTER;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                md_next   = IDX_W'(mid_sum >> 1);
                rd_addr_a = md_next;
                rd_addr_b = md_next + IDX_W'(1);
                st_next   = ns;
                ed_next   = ne;
                if (x_reg == rd_a_reg) begin
                    raw_next   = md_times10;
                    state_next = ST_FILTER;
                end else if ((x_reg < rd_a_reg && x_reg > rd_b_reg)
                             || (ns == st_reg && ne == ed_reg) || ns >= ne) begin
                    // between two entries, stalled or emptied interval
                    raw_next   = md_times10 + ntczf_pkg::RAW_W'(5);
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER: begin
                if (!m_tvalid_reg || m_tready) begin
                    sum_next      = sum_sat;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ntczf_pkg::OUT_W'({filt_val,
                                                       raw_reg[ntczf_pkg::TEMP_W-1:0],
                                                       held_zone_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            table_mem[in_index[IDX_W-1:0]] <= in_value;
        end
        rd_a_reg <= table_mem[rd_addr_a];
        rd_b_reg <= table_mem[rd_addr_b];
    end

    // State, configuration and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            held_zone_reg   <= ntczf_pkg::ZONE_INIT;
            count_reg       <= '0;
            sum_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            open_thr_reg    <= '0;
            recover_thr_reg <= '0;
            over_thr_reg    <= '0;
            short_thr_reg   <= '0;
            temp_limit_reg  <= ntczf_pkg::TEMP_LIMIT_RST;
            debounce_reg    <= ntczf_pkg::DEBOUNCE_RST;
        end else begin
            state_reg     <= state_next;
            held_zone_reg <= held_zone_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    ntczf_pkg::REG_OPEN_THR:    open_thr_reg    <= cfg_data[7:0];
                    ntczf_pkg::REG_RECOVER_THR: recover_thr_reg <= cfg_data[7:0];
                    ntczf_pkg::REG_OVER_THR:    over_thr_reg    <= cfg_data[7:0];
                    ntczf_pkg::REG_SHORT_THR:   short_thr_reg   <= cfg_data[7:0];
                    ntczf_pkg::REG_TEMP_LIMIT:  temp_limit_reg  <= cfg_data;
                    ntczf_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        // payload registers
        x_reg       <= x_next;
        st_reg      <= st_next;
        ed_reg      <= ed_next;
        md_reg      <= md_next;
        raw_reg     <= raw_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== rtl/ntczf_checker.sv =====
// Port-level checker for ntc_zone_and_temperature_filter, bound to the top level.
// Depends on assert_macros.svh and ntczf_pkg.
`include "assert_macros.svh"

module ntczf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ntczf_pkg::OUT_W-1:0] m_tdata
);

    // A stalled result keeps its payload
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A sample request keeps the block busy in the following cycle
    `ASSERT_NXT(a_busy_after_sample, aclk, aresetn, s_tvalid && s_tready && s_tuser == ntczf_pkg::MODE_SAMPLE, !s_tready)

    // The held zone is a defined zone code
    `ASSERT_IMP(a_zone_code, aclk, aresetn, m_tvalid, m_tdata[2:0] <= ntczf_pkg::ZONE_SHORT)

    // A new result never shows right after an accepted request
    `ASSERT_IMP(a_min_latency, aclk, aresetn, $rose(m_tvalid), !$past(s_tvalid && s_tready))

endmodule

bind ntc_zone_and_temperature_filter ntczf_checker u_ntczf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_ntc_zone_and_temperature_filter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ntc_zone_and_temperature_filter: table loads, zone debounce,
// table search and the running-average filter, checked against an in-bench predictor or typed-in readings.
// Depends on ntczf_pkg and the block's RTL; needs no files or arguments.
module tb_ntc_zone_and_temperature_filter;

    localparam int ZONE_W            = ntczf_pkg::ZONE_W;
    localparam int TEMP_W            = ntczf_pkg::TEMP_W;
    localparam int SUM_W             = ntczf_pkg::SUM_W;
    localparam int CFG_W             = ntczf_pkg::CFG_W;
    localparam int IN_W              = ntczf_pkg::IN_W;
    localparam int OUT_W             = ntczf_pkg::OUT_W;
    localparam int TABLE_ENTRIES     = 180;
    localparam int FILTER_WEIGHT     = 1 << ntczf_pkg::FILT_SHIFT;
    localparam int SUM_LIMIT         = (1 << SUM_W) - 1;
    localparam int FILT_LIMIT        = (1 << TEMP_W) - 1;
    localparam int RAW_LSB           = ZONE_W;
    localparam int FILT_LSB          = ZONE_W + TEMP_W;
    localparam int PAD_LSB           = ZONE_W + 2 * TEMP_W;
    localparam int SETTLE_CYCLES     = 24;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int PHASES            = 8;
    localparam int SAMPLES_PER_PHASE = 48;
    localparam int MAX_REPORTS       = 10;
    localparam logic [TEMP_W-1:0] COLD_END_TEMP = TEMP_W'((TABLE_ENTRIES - 1) * 10);

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [TEMP_W-1:0] raw_temp;
        logic [TEMP_W-1:0] filt_temp;
    } reading_t;

    typedef enum logic [1:0] {STEP_SAMPLE, STEP_TABLE, STEP_CONFIG} step_kind_e;

    typedef struct {
        step_kind_e       kind;
        logic [7:0]       arg;      // sample, table index or register index
        logic [CFG_W-1:0] value;    // table value or register data
        bit               typed;    // use the typed-in reading instead of the predictor
        reading_t         want;
    } plan_step_t;

    localparam reading_t NO_READING = '0;

    // DUT ports
    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;     // sample[7:0], table_index[15:8], table_value[23:16]
    logic             s_tuser   = ntczf_pkg::MODE_SAMPLE;  // mode[0]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;            // zone[2:0], raw_temperature[13:3],
                                          // filtered_temperature[24:14], zero

    // Predictor state and configuration
    logic [7:0]        zone_bound [4];
    logic [TEMP_W-1:0] temp_limit_q;
    logic [7:0]        debounce_q;
    logic [7:0]        ntc_table [TABLE_ENTRIES];
    logic [ZONE_W-1:0] held_zone_q;
    int                mismatch_q;
    int                running_sum_q;

    reading_t   readings_due[$];
    plan_step_t plan[$];
    reading_t   oldest_due;
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         ready_hold  = 0;
    bit         steady_flow = 1'b0;

    ntc_zone_and_temperature_filter #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Binary search of the descending table; x is the inverted reading
    function automatic logic [TEMP_W-1:0] search_table(input logic [7:0] x);
        int lo, hi, mid, nlo, nhi, steps;
        lo = 0;
        hi = TABLE_ENTRIES - 1;
        mid = 0;
        steps = 0;
        if (x >= ntc_table[0]) return '0;
        if (x <= ntc_table[TABLE_ENTRIES-1]) return COLD_END_TEMP;
        while (lo < hi && steps < 2 * TABLE_ENTRIES) begin
            mid = (lo + hi) / 2;
            if (x == ntc_table[mid]) break;
            if (x < ntc_table[mid] && x > ntc_table[mid+1]) break;
            nlo = lo;
            nhi = hi;
            if (x > ntc_table[mid]) nhi = mid;
            else nlo = mid;
            // interval stopped shrinking
            if (nlo == lo && nhi == hi) break;
            lo = nlo;
            hi = nhi;
            steps++;
        end
        if (x == ntc_table[mid]) return TEMP_W'(mid * 10);
        return TEMP_W'(mid * 10 + 5);
    endfunction

    // Zone debounce, lookup and filter for one sample; updates predictor state
    function automatic reading_t predict_reading(input logic [7:0] s);
        reading_t r;
        int zone, t;
        zone = 0;
        while (zone < 4 && !(s < zone_bound[zone])) zone++;
        zone++;

        if (held_zone_q == ZONE_W'(zone)) mismatch_q = 0;
        else if (mismatch_q < ntczf_pkg::COUNT_MAX) mismatch_q++;
        if (mismatch_q > debounce_q) held_zone_q = ZONE_W'(zone);

        r.raw_temp = search_table(8'hFF - s);
        t = r.raw_temp;
        if (t == 0 || t > temp_limit_q) t = 0;
        // seed an empty sum with the first reading
        if (running_sum_q == 0)
            running_sum_q = (t * FILTER_WEIGHT > SUM_LIMIT) ? SUM_LIMIT : t * FILTER_WEIGHT;
        running_sum_q = running_sum_q - running_sum_q / FILTER_WEIGHT + t;
        if (running_sum_q > SUM_LIMIT) running_sum_q = SUM_LIMIT;
        r.filt_temp = (running_sum_q / FILTER_WEIGHT > FILT_LIMIT) ?
                      TEMP_W'(FILT_LIMIT) : TEMP_W'(running_sum_q / FILTER_WEIGHT);
        r.zone = held_zone_q;
        return r;
    endfunction

    function automatic plan_step_t plan_row(input step_kind_e kind, input int arg,
                                            input int value, input bit typed = 1'b0,
                                            input reading_t want = NO_READING);
        plan_step_t row;
        row.kind  = kind;
        row.arg   = 8'(arg);
        row.value = CFG_W'(value);
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic void check_field(input string label, input int got, input int want);
        if (got != want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch on %s at %0t: expected %0d, got %0d",
                         label, $time, want, got);
        end
    endfunction

    // One request on the input stream; returns right after the accepting edge
    task automatic push_request(input logic mode, input logic [7:0] sample,
                                input logic [7:0] tbl_index, input logic [7:0] tbl_value);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {tbl_value, tbl_index, sample};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_sample(input logic [7:0] s, input bit typed, input reading_t want);
        reading_t predicted;
        push_request(ntczf_pkg::MODE_SAMPLE, s, 8'($urandom), 8'($urandom));
        predicted = predict_reading(s);
        readings_due.push_back(typed ? want : predicted);
    endtask

    task automatic send_table_entry(input logic [7:0] idx, input logic [7:0] val);
        push_request(ntczf_pkg::MODE_TABLE, 8'($urandom), idx, val);
        // out-of-range indexes are dropped by the block
        if (idx < TABLE_ENTRIES) ntc_table[idx] = val;
    endtask

    // Wait until every result is back and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            ntczf_pkg::REG_OPEN_THR, ntczf_pkg::REG_RECOVER_THR,
            ntczf_pkg::REG_OVER_THR, ntczf_pkg::REG_SHORT_THR:
                zone_bound[idx[1:0]] = 8'(value);
            ntczf_pkg::REG_TEMP_LIMIT: temp_limit_q = TEMP_W'(value);
            ntczf_pkg::REG_DEBOUNCE:   debounce_q = 8'(value);
            default: ;
        endcase
    endtask

    task automatic run_step(input plan_step_t row);
        case (row.kind)
            STEP_SAMPLE: send_sample(row.arg, row.typed, row.want);
            STEP_TABLE:  send_table_entry(row.arg, 8'(row.value));
            STEP_CONFIG: begin
                drain();
                write_register(3'(row.arg), row.value);
            end
            default: ;
        endcase
    endtask

    // Full table reload: descending with steps of 0..2, or noise
    task automatic load_table(input bit ordered);
        int level, i;
        level = $urandom_range(180, 255);
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            send_table_entry(8'(i), ordered ? 8'(level) : 8'($urandom));
            level = level - int'($urandom_range(0, 2));
            if (level < 0) level = 0;
        end
    endtask

    // Register settings per phase, extremes on fixed phases
    task automatic configure_phase(input int p);
        int bounds[$];
        int k, limit, debounce;
        for (k = 0; k < 4; k++) begin
            case (p)
                1:       bounds.push_back(0);
                2:       bounds.push_back(255);
                default: bounds.push_back($urandom_range(0, 255));
            endcase
        end
        // one phase keeps the thresholds out of order
        if (p != 5) bounds.sort();
        limit = (p == 3) ? 0 : (p == 5) ? FILT_LIMIT : $urandom_range(200, 1795);
        if (p == 0) debounce = 0;
        else if (p == 6) debounce = 254;
        else if ($urandom_range(0, 3) == 0) debounce = $urandom_range(0, 254);
        else debounce = $urandom_range(0, 6);
        write_register(ntczf_pkg::REG_OPEN_THR, bounds[0]);
        write_register(ntczf_pkg::REG_RECOVER_THR, bounds[1]);
        write_register(ntczf_pkg::REG_OVER_THR, bounds[2]);
        write_register(ntczf_pkg::REG_SHORT_THR, bounds[3]);
        write_register(ntczf_pkg::REG_TEMP_LIMIT, limit);
        write_register(ntczf_pkg::REG_DEBOUNCE, debounce);
    endtask

    // Result checker and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result at %0t: %h", $time, m_tdata);
                end else begin
                    oldest_due = readings_due.pop_front();
                    check_field("zone", m_tdata[ZONE_W-1:0], oldest_due.zone);
                    check_field("raw_temperature", m_tdata[RAW_LSB +: TEMP_W],
                                oldest_due.raw_temp);
                    check_field("filtered_temperature", m_tdata[FILT_LSB +: TEMP_W],
                                oldest_due.filt_temp);
                    check_field("padding", m_tdata[OUT_W-1:PAD_LSB], 0);
                end
                ready_hold = steady_flow ? 0 : $urandom_range(0, 4);
            end
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int i, p, level;
        logic [7:0] s;

        // predictor state after reset
        foreach (zone_bound[k]) zone_bound[k] = '0;
        temp_limit_q  = ntczf_pkg::TEMP_LIMIT_RST;
        debounce_q    = ntczf_pkg::DEBOUNCE_RST;
        held_zone_q   = ntczf_pkg::ZONE_INIT;
        mismatch_q    = 0;
        running_sum_q = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // known table: duplicate entries in the upper half, gaps of two in the lower
        for (i = 0; i < TABLE_ENTRIES; i++)
            send_table_entry(8'(i), 8'(i < 90 ? 240 - i / 2 : 195 - 2 * (i - 90)));

        // directed part: table ends and reset values first
        plan.push_back(plan_row(STEP_SAMPLE, 0, 0, 1'b1,
                                reading_t'{ntczf_pkg::ZONE_INIT, 11'd0, 11'd0}));
        plan.push_back(plan_row(STEP_SAMPLE, 255, 0, 1'b1,
                                reading_t'{ntczf_pkg::ZONE_INIT, COLD_END_TEMP, 11'd0}));
        plan.push_back(plan_row(STEP_SAMPLE, 238, 0, 1'b1,
                                reading_t'{ntczf_pkg::ZONE_INIT, COLD_END_TEMP, 11'd0}));
        plan.push_back(plan_row(STEP_SAMPLE, 15, 0, 1'b1,
                                reading_t'{ntczf_pkg::ZONE_INIT, 11'd0, 11'd0}));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_DEBOUNCE, 0));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_OPEN_THR, 40));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_RECOVER_THR, 80));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_OVER_THR, 120));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_SHORT_THR, 200));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_TEMP_LIMIT, FILT_LIMIT));
        // zero debounce: the first mismatch moves the held zone
        plan.push_back(plan_row(STEP_SAMPLE, 10, 0, 1'b1,
                                reading_t'{ntczf_pkg::ZONE_OPEN, 11'd0, 11'd0}));
        // zone boundaries
        plan.push_back(plan_row(STEP_SAMPLE, 39, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 40, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 119, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 120, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 199, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 200, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 255, 0));
        // between two entries, exact hit, duplicate entries
        plan.push_back(plan_row(STEP_SAMPLE, 61, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 62, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 25, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 30, 0));
        // zero limit forces every temperature out of the filter
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_TEMP_LIMIT, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 128, 0));
        plan.push_back(plan_row(STEP_CONFIG, ntczf_pkg::REG_DEBOUNCE, 254));
        plan.push_back(plan_row(STEP_SAMPLE, 0, 0));
        // out-of-range table index is dropped; end entries rewritten
        plan.push_back(plan_row(STEP_TABLE, 255, 0));
        plan.push_back(plan_row(STEP_TABLE, 0, 240));
        plan.push_back(plan_row(STEP_TABLE, 179, 17));
        plan.push_back(plan_row(STEP_SAMPLE, 238, 0));
        plan.push_back(plan_row(STEP_SAMPLE, 16, 0));

        foreach (plan[k]) run_step(plan[k]);

        // random phases: readings drift so zones hold for runs, with jumps and noise
        for (p = 0; p < PHASES; p++) begin
            drain();
            steady_flow = (p % 3 == 1);
            configure_phase(p);
            if (p == 0 || p == 3) load_table(1'b1);
            else if (p == 6) load_table(1'b0);
            level = $urandom_range(0, 255);
            i = 0;
            while (i < SAMPLES_PER_PHASE) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_table_entry(8'($urandom), 8'($urandom));
                end else begin
                    case ($urandom_range(0, 7))
                        0: s = 8'($urandom);
                        1: s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        default: begin
                            level = level + int'($urandom_range(0, 12)) - 6;
                            if (level < 0) level = 0;
                            if (level > 255) level = 255;
                            s = 8'(level);
                        end
                    endcase
                    send_sample(s, 1'b0, NO_READING);
                    i++;
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== ntc_zone_and_temperature_filter.f =====
+incdir+rtl
rtl/ntczf_pkg.sv
rtl/ntc_zone_and_temperature_filter.sv
rtl/ntczf_checker.sv
test/tb_ntc_zone_and_temperature_filter.sv
